// ----- rtl/mbr_pt_pkg.sv -----
// ----------------------------------------------------------------------------
// MBR partition table parser: shared types and constants
// Payload structs for both channels, captured entry layout, sector offsets
// and the state encoding of the evaluation sequencer.
// ----------------------------------------------------------------------------
package mbr_pt_pkg;

	localparam int MaxSlots = 4;
	localparam int JobDepth = 2;

	localparam logic [8:0] TableBase = 9'd446;
	localparam logic [8:0] SigPosLow = 9'd510;
	localparam logic [8:0] SigPosHigh = 9'd511;

	localparam logic [7:0] StatusActive = 8'h80;
	localparam logic [7:0] StatusIdle = 8'h00;
	localparam logic [7:0] SigByteLow = 8'h55;
	localparam logic [7:0] SigByteHigh = 8'hAA;

	localparam logic KindEntry = 1'b0;
	localparam logic KindSummary = 1'b1;

	// entry field offsets inside a 16-byte slot
	localparam logic [3:0] OffStatus = 4'd0;
	localparam logic [3:0] OffType = 4'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       sector_start;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [1:0]  entry_index;
		logic [7:0]  partition_type;
		logic [31:0] first_block;
		logic [31:0] block_total;
		logic        signature_ok;
		logic [2:0]  valid_count;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [7:0]  status_code;
		logic [7:0]  type_code;
		logic [31:0] first_block;
		logic [31:0] block_total;
	} entry_t;

	typedef struct packed {
		logic                  sig_ok;
		entry_t [MaxSlots-1:0] entries;
	} job_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_ENTRY,
		BS_SUM
	} back_state_t;

endpackage

// ----- rtl/mbr_pt_front.sv -----
// ----------------------------------------------------------------------------
// MBR partition table parser: front end
// Tracks the byte position in the sector, captures the table entries and the
// signature, and hands a complete sector job to the queue on the last byte.
// ----------------------------------------------------------------------------
module mbr_pt_front #(
	parameter int TABLE_ENTRIES = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  mbr_pt_pkg::in_item_t item,
	output logic                 job_push,
	output mbr_pt_pkg::job_t     job
);
	import mbr_pt_pkg::*;

	localparam logic [2:0] SlotLimit = 3'(TABLE_ENTRIES);

	logic [8:0]            pos_q;
	logic [8:0]            pos;
	logic [7:0]            sig_low_q;
	entry_t [MaxSlots-1:0] entry_q;
	logic [8:0]            rel_full;
	logic [1:0]            slot;
	logic [3:0]            off;
	logic                  in_table;

	assign pos = item.sector_start ? 9'd0 : pos_q;
	assign rel_full = pos - TableBase;
	assign slot = rel_full[5:4];
	assign off = rel_full[3:0];
	assign in_table = (pos >= TableBase) && (pos < SigPosLow) && ({1'b0, slot} < SlotLimit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= pos + 9'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (pos == SigPosLow) begin
				sig_low_q <= item.data_byte;
			end
			if (in_table) begin
				case (off) inside
					OffStatus: entry_q[slot].status_code <= item.data_byte;
					OffType:   entry_q[slot].type_code <= item.data_byte;
					[4'd8:4'd11]: entry_q[slot].first_block[8*off[1:0] +: 8] <= item.data_byte;
					[4'd12:4'd15]: entry_q[slot].block_total[8*off[1:0] +: 8] <= item.data_byte;
					default: ;
				endcase
			end
		end
	end

	assign job_push = accept && (pos == SigPosHigh);
	assign job.sig_ok = (sig_low_q == SigByteLow) && (item.data_byte == SigByteHigh);
	assign job.entries = entry_q;

endmodule

// ----- rtl/mbr_pt_jobq.sv -----
// ----------------------------------------------------------------------------
// MBR partition table parser: sector job queue
// Short queue of captured sectors between the front end and the evaluator.
// ----------------------------------------------------------------------------
module mbr_pt_jobq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mbr_pt_pkg::job_t push_job,
	output logic             full,
	output logic             valid,
	output mbr_pt_pkg::job_t head,
	input  logic             pop
);
	import mbr_pt_pkg::*;

	localparam int PtrW = $clog2(JobDepth);
	localparam int CntW = $clog2(JobDepth + 1);

	job_t              slot_q [JobDepth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign full = (count_q == CntW'(JobDepth));
	assign valid = (count_q != '0);
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(JobDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(JobDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

// ----- rtl/mbr_pt_back.sv -----
// ----------------------------------------------------------------------------
// MBR partition table parser: evaluator
// Walks each slot of a signed sector, one per cycle while output has room,
// checks it vs the device block count, loads valid ones, then the summary.
// ----------------------------------------------------------------------------
module mbr_pt_back #(
	parameter int TABLE_ENTRIES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         dev_blocks,
	input  logic                job_valid,
	input  mbr_pt_pkg::job_t    job,
	output logic                job_pop,
	output logic                empty,
	input  logic                pop,
	output mbr_pt_pkg::result_t result
);
	import mbr_pt_pkg::*;

	localparam logic [1:0] LastSlot = 2'(TABLE_ENTRIES - 1);
	localparam logic [2:0] SlotLimit = 3'(TABLE_ENTRIES);

	back_state_t state_q;
	back_state_t state_d;
	logic [1:0]  idx_q;
	logic [2:0]  cnt_q;
	result_t     out_q;
	logic        out_valid_q;
	result_t     res;
	logic        load;
	logic        step;
	logic        space;
	entry_t      cur;
	logic [32:0] end_sum;
	logic        cur_ok;

	assign space = !out_valid_q || pop;
	assign cur = job.entries[idx_q];
	assign end_sum = {1'b0, cur.first_block} + {1'b0, cur.block_total};
	assign cur_ok = (cur.type_code != 8'd0)
		&& ((cur.status_code == StatusActive) || (cur.status_code == StatusIdle))
		&& (cur.first_block < dev_blocks)
		&& (end_sum <= {1'b0, dev_blocks});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BS_IDLE: begin
				if (job_valid) begin
					state_d = job.sig_ok ? BS_ENTRY : BS_SUM;
				end
			end
			BS_ENTRY: begin
				if (step && (idx_q == LastSlot)) begin
					state_d = BS_SUM;
				end
			end
			BS_SUM: begin
				if (space) begin
					state_d = BS_IDLE;
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	always_comb begin
		load = 1'b0;
		step = 1'b0;
		job_pop = 1'b0;
		res = '0;
		unique case (state_q)
			BS_IDLE: ;
			BS_ENTRY: begin
				if (!cur_ok) begin
					step = 1'b1;
				end else if (space) begin
					step = 1'b1;
					load = 1'b1;
					res.result_kind = KindEntry;
					res.entry_index = idx_q;
					res.partition_type = cur.type_code;
					res.first_block = cur.first_block;
					res.block_total = cur.block_total;
					res.signature_ok = 1'b1;
				end
			end
			BS_SUM: begin
				if (space) begin
					load = 1'b1;
					job_pop = 1'b1;
					res.result_kind = KindSummary;
					res.signature_ok = job.sig_ok;
					res.valid_count = cnt_q;
					res.last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
			idx_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BS_IDLE) begin
				idx_q <= '0;
				cnt_q <= '0;
			end else if (step) begin
				idx_q <= idx_q + 2'd1;
				if (load) begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
			// hold the beat until taken; a new load may replace it in the same cycle
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	assign empty = !out_valid_q;
	assign result = out_q;

`ifndef NO_ASSERTIONS
	a_pop_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid)
		else $error("job popped from an empty queue");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= SlotLimit)
		else $error("valid entry count exceeds table size");

	a_entry_needs_sig: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BS_ENTRY) |-> job_valid && job.sig_ok)
		else $error("entry walk without a signed sector");

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> out_valid_q && result.last && (result.valid_count == $past(cnt_q)))
		else $error("summary not presented after job retired");
`endif

endmodule

// ----- rtl/mbr_partition_table_parser_core.sv -----
// ----------------------------------------------------------------------------
// MBR partition table parser
// Byte-stream boot sector parser reporting valid partition entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue (push/full, item): one sector byte per beat, sector_start on
//   byte 0 restarts the position count; otherwise positions wrap at 512.
//   Result queue (empty/pop, result): after byte 511 one beat per valid entry
//   (kind 0, none if the signature fails) then a summary beat (kind 1, last = 1).
//   Config channel (cfg_valid/cfg_ready, cfg_data): device block count,
//   always ready; write it only while no sector results are pending.
// Timing:
//   A byte is taken every cycle while full is low. Byte 511 pushes the sector job;
//   the evaluator then walks one slot per cycle while the result register has
//   space (invalid slots never wait), and the summary follows the entries. Up to
//   two finished sectors wait in the job queue; full rises when both are held.
// Reset clears the position count, the job queue, the evaluator and the
// result valid flag; the block count reads 0. A stalled pop holds the evaluator.
// ----------------------------------------------------------------------------
module mbr_partition_table_parser_core #(
	parameter int TABLE_ENTRIES = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  mbr_pt_pkg::in_item_t item,
	output logic                 empty,
	input  logic                 pop,
	output mbr_pt_pkg::result_t  result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [31:0]          cfg_data
);
	import mbr_pt_pkg::*;

	logic [31:0] dev_blocks_q;
	logic        accept;
	logic        job_push;
	job_t        push_job;
	logic        job_valid;
	job_t        head_job;
	logic        job_pop;

	assign cfg_ready = 1'b1;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_blocks_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			dev_blocks_q <= cfg_data;
		end
	end

	mbr_pt_front #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (item),
		.job_push(job_push),
		.job     (push_job)
	);

	mbr_pt_jobq u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.push_job(push_job),
		.full    (full),
		.valid   (job_valid),
		.head    (head_job),
		.pop     (job_pop)
	);

	mbr_pt_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dev_blocks(dev_blocks_q),
		.job_valid (job_valid),
		.job       (head_job),
		.job_pop   (job_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
